// File: design/tph_pkg.sv
// Shared constants and types for the trapezoid pulse-height block.
// No dependencies; used by trapezoid_pulse_height.sv and by the bench.
`timescale 1ns / 1ps

package tph_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 28;
    localparam int HEIGHT_W  = 25;
    localparam int CFG_W     = 11;
    localparam int FRAC_W    = 8;
    localparam int DIV_BITS  = SUM_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    localparam int MAX_WINDOW = 1024;
    localparam int MAX_GAP    = 1024;
    localparam int MAX_RECORD = 131072;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 11'd500;
    localparam logic [CFG_W-1:0] GAP_RESET    = 11'd100;

    typedef enum logic [0:0] {
        CFG_WINDOW = 1'b0,
        CFG_GAP    = 1'b1
    } cfg_index_t;

endpackage

// File: design/trapezoid_pulse_height.sv
// Top level: trapezoidal shaping filter and pulse-height measurement.
// Depends on tph_pkg and tph_ram (sample delay line).
//
//  channel | ports                          | direction | beat
//  --------+--------------------------------+-----------+---------------------------
//  s_      | s_valid s_ready s_sample s_last| in        | one sample
//  m_      | m_valid m_ready m_height_q8    | out       | one height per record
//          | m_too_short                    |           |
//  cfg_    | cfg_valid cfg_ready cfg_index  | in        | one register write
//          | cfg_data                       |           |
//
// A new sample waits until the last one is written: the delay line has one read
// port, and the three taps (L, G+L, G+2L back) are read in turn before the write.
// After a last sample the bit-serial divider forms (max-min)*256/L and the result is
// loaded into the output register; a too-short record skips the divider.
// Reset is synchronous; the delay line needs no clearing pass (taps gated by count).
// Register writes are taken only between samples and go ahead of a waiting sample.
// Results sit in an output register; samples keep flowing while it waits, and only
// the completion of the next record's height waits for it to drain.
`timescale 1ns / 1ps

module trapezoid_pulse_height #(
    parameter int MaxWindow = tph_pkg::MAX_WINDOW,
    parameter int MaxGap    = tph_pkg::MAX_GAP,
    parameter int MaxRecord = tph_pkg::MAX_RECORD
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [tph_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tph_pkg::HEIGHT_W-1:0]      m_height_q8,
    output logic                              m_too_short,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [0:0]                        cfg_index,
    input  logic [tph_pkg::CFG_W-1:0]         cfg_data
);

    localparam int LineDepth = 2 * MaxWindow + MaxGap;
    localparam int AW        = $clog2(LineDepth);
    localparam int OW        = $clog2(LineDepth + 1);
    localparam int CW        = $clog2(MaxRecord + 1);
    localparam int LW        = $clog2(MaxWindow + 1);
    localparam int RW        = LW + 1;
    localparam int SW        = tph_pkg::SUM_W;
    localparam int DW        = tph_pkg::DIV_BITS;
    localparam int HW        = tph_pkg::HEIGHT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAP_B,
        ST_TAP_C,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    state_t state_reg;

    logic [tph_pkg::CFG_W-1:0] window_reg;
    logic [tph_pkg::CFG_W-1:0] gap_reg;

    logic [AW-1:0]                       ptr_reg;
    logic [CW-1:0]                       count_reg;
    logic signed [SW-1:0]                sum_reg;
    logic signed [SW-1:0]                acc_reg;
    logic signed [SW-1:0]                max_reg;
    logic signed [SW-1:0]                min_reg;
    logic                                ext_valid_reg;
    logic signed [tph_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                last_reg;

    logic [DW-1:0]                    dividend_reg;
    logic [RW-2:0]                    rem_reg;
    logic [LW-1:0]                    divisor_reg;
    logic [HW-1:0]                    quot_reg;
    logic                             short_reg;
    logic [tph_pkg::DIV_CNT_W-1:0]    div_cnt_reg;

    logic                  m_valid_reg;
    logic [HW-1:0]         m_height_reg;
    logic                  m_short_reg;

    // effective window and gap
    logic [LW-1:0] win_eff;
    logic [OW-1:0] gap_eff;
    logic [OW-1:0] off_l;
    logic [OW-1:0] off_gl;
    logic [OW-1:0] off_g2l;

    always_comb begin
        if (window_reg == '0) begin
            win_eff = LW'(1);
        end else if (32'(window_reg) > 32'(MaxWindow)) begin
            win_eff = LW'(MaxWindow);
        end else begin
            win_eff = LW'(window_reg);
        end
        if (32'(gap_reg) > 32'(MaxGap)) begin
            gap_eff = OW'(MaxGap);
        end else begin
            gap_eff = OW'(gap_reg);
        end
        off_l   = OW'(win_eff);
        off_gl  = gap_eff + off_l;
        off_g2l = off_gl + off_l;
    end

    logic has_l;
    logic has_gl;
    logic has_g2l;

    assign has_l   = 32'(count_reg) >= 32'(off_l);
    assign has_gl  = 32'(count_reg) >= 32'(off_gl);
    assign has_g2l = 32'(count_reg) >= 32'(off_g2l);

    // read address: ptr - offset, modulo the line depth
    logic [OW-1:0] tap_off;
    logic [OW-1:0] ptr_ext;
    logic [OW-1:0] addr_wide;
    logic [AW-1:0] ram_raddr;

    always_comb begin
        case (state_reg)
            ST_TAP_B: tap_off = off_gl;
            ST_TAP_C: tap_off = off_g2l;
            default:  tap_off = off_l;
        endcase
        ptr_ext = OW'(ptr_reg);
        if (ptr_ext >= tap_off) begin
            addr_wide = ptr_ext - tap_off;
        end else begin
            addr_wide = ptr_ext + (OW'(LineDepth) - tap_off);
        end
        ram_raddr = AW'(addr_wide);
    end

    logic [tph_pkg::SAMPLE_W-1:0]        ram_rdata;
    logic signed [tph_pkg::SAMPLE_W-1:0] tap;
    logic                                ram_we;

    assign ram_we = (state_reg == ST_UPDATE);
    assign tap    = ram_rdata;

    tph_ram #(
        .WIDTH (tph_pkg::SAMPLE_W),
        .DEPTH (LineDepth)
    ) u_delay_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (sample_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic signed [SW-1:0] tap_ext;
    logic signed [SW-1:0] new_sum;
    logic [SW-1:0]        diff_wide;
    logic [RW-1:0]        trial;
    logic                 trial_ge;

    assign tap_ext   = SW'(tap);
    assign new_sum   = acc_reg + (has_g2l ? tap_ext : SW'(0));
    assign diff_wide = SW'(max_reg - min_reg);
    assign trial     = {rem_reg, dividend_reg[DW-1]};
    assign trial_ge  = trial >= RW'(divisor_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            window_reg    <= tph_pkg::WINDOW_RESET;
            gap_reg       <= tph_pkg::GAP_RESET;
            ptr_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            ext_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (tph_pkg::cfg_index_t'(cfg_index))
                    tph_pkg::CFG_WINDOW: window_reg <= cfg_data;
                    tph_pkg::CFG_GAP:    gap_reg    <= cfg_data;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && state_reg != ST_OUTPUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        sample_reg <= s_sample;
                        last_reg   <= s_last;
                        if (has_g2l) begin
                            if (!ext_valid_reg) begin
                                max_reg       <= sum_reg;
                                min_reg       <= sum_reg;
                                ext_valid_reg <= 1'b1;
                            end else begin
                                if (sum_reg > max_reg) max_reg <= sum_reg;
                                if (sum_reg < min_reg) min_reg <= sum_reg;
                            end
                        end
                        state_reg <= ST_TAP_B;
                    end
                end
                ST_TAP_B: begin
                    acc_reg   <= sum_reg + SW'(sample_reg) - (has_l ? tap_ext : SW'(0));
                    state_reg <= ST_TAP_C;
                end
                ST_TAP_C: begin
                    acc_reg   <= acc_reg - (has_gl ? tap_ext : SW'(0));
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (ptr_reg == AW'(LineDepth - 1)) begin
                        ptr_reg <= '0;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    if (last_reg) begin
                        sum_reg       <= '0;
                        count_reg     <= '0;
                        ext_valid_reg <= 1'b0;
                        if (ext_valid_reg) begin
                            dividend_reg <= {diff_wide, tph_pkg::FRAC_W'(0)};
                            rem_reg      <= '0;
                            divisor_reg  <= win_eff;
                            quot_reg     <= '0;
                            short_reg    <= 1'b0;
                            div_cnt_reg  <= tph_pkg::DIV_CNT_W'(DW - 1);
                            state_reg    <= ST_DIVIDE;
                        end else begin
                            quot_reg  <= '0;
                            short_reg <= 1'b1;
                            state_reg <= ST_OUTPUT;
                        end
                    end else begin
                        sum_reg <= new_sum;
                        if (32'(count_reg) < 32'(MaxRecord)) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIVIDE: begin
                    dividend_reg <= {dividend_reg[DW-2:0], 1'b0};
                    if (trial_ge) begin
                        rem_reg <= (RW - 1)'(trial - RW'(divisor_reg));
                    end else begin
                        rem_reg <= trial[RW-2:0];
                    end
                    quot_reg <= {quot_reg[HW-2:0], trial_ge};
                    if (div_cnt_reg == '0) begin
                        state_reg <= ST_OUTPUT;
                    end else begin
                        div_cnt_reg <= div_cnt_reg - 1'b1;
                    end
                end
                ST_OUTPUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_height_reg <= quot_reg;
                        m_short_reg  <= short_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_height_q8 = m_height_reg;
    assign m_too_short = m_short_reg;

endmodule

// File: design/tph_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3072
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: bench/trapezoid_pulse_height_test.sv
// Self-checking bench for trapezoid_pulse_height: drives sample records and register
// writes, predicts each pulse height and compares it with the m_ beat.
// Depends on tph_pkg and the design under design/.
`timescale 1ns / 1ps

module trapezoid_pulse_height_test;

    localparam int LINE_DEPTH  = 2 * tph_pkg::MAX_WINDOW + tph_pkg::MAX_GAP;
    localparam int SETTLE      = 64;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [tph_pkg::HEIGHT_W-1:0] height_q8;
        logic                         too_short;
    } pulse_result_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic signed [tph_pkg::SAMPLE_W-1:0] s_sample = '0;
    logic                                s_last = 1'b0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [tph_pkg::HEIGHT_W-1:0]        m_height_q8;
    logic                                m_too_short;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    tph_pkg::cfg_index_t                 cfg_index = tph_pkg::CFG_WINDOW;
    logic [tph_pkg::CFG_W-1:0]           cfg_data = '0;

    // shaper model state
    logic [tph_pkg::CFG_W-1:0]           reg_window = tph_pkg::WINDOW_RESET;
    logic [tph_pkg::CFG_W-1:0]           reg_gap = tph_pkg::GAP_RESET;
    bit signed [tph_pkg::SAMPLE_W-1:0]   sample_hist [LINE_DEPTH];
    int unsigned                         hist_wr = 0;
    logic signed [tph_pkg::SUM_W-1:0]    trap_acc = '0;
    int unsigned                         rec_count = 0;
    logic signed [tph_pkg::SUM_W-1:0]    t_hi = '0;
    logic signed [tph_pkg::SUM_W-1:0]    t_lo = '0;
    bit                                  t_seen = 1'b0;
    pulse_result_t                       pending_heights[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_left = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int unsigned err_count = 0;
    int unsigned samples_sent = 0;
    int unsigned heights_checked = 0;
    int unsigned short_seen = 0;
    int unsigned cycle_count = 0;

    trapezoid_pulse_height uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_height_q8 (m_height_q8),
        .m_too_short (m_too_short),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_asked;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        pulse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_heights.size() == 0) begin
                $display("%0t: unexpected height beat, expected none, got height %0d short %0b",
                         $time, m_height_q8, m_too_short);
                err_count++;
            end else begin
                want = pending_heights.pop_front();
                heights_checked++;
                if (m_too_short) short_seen++;
                if (m_height_q8 !== want.height_q8) begin
                    $display("%0t: height_q8 mismatch, expected %0d, got %0d",
                             $time, want.height_q8, m_height_q8);
                    err_count++;
                end
                if (m_too_short !== want.too_short) begin
                    $display("%0t: too_short mismatch, expected %0b, got %0b",
                             $time, want.too_short, m_too_short);
                    err_count++;
                end
            end
        end
    end

    function automatic int unsigned clip_window(input logic [tph_pkg::CFG_W-1:0] w);
        if (w == 0) return 1;
        if (w > tph_pkg::MAX_WINDOW) return tph_pkg::MAX_WINDOW;
        return w;
    endfunction

    function automatic int unsigned clip_gap(input logic [tph_pkg::CFG_W-1:0] g);
        return (g > tph_pkg::MAX_GAP) ? tph_pkg::MAX_GAP : g;
    endfunction

    function automatic logic signed [tph_pkg::SAMPLE_W-1:0] past_sample(
        input int unsigned back);
        return sample_hist[(hist_wr + LINE_DEPTH - back) % LINE_DEPTH];
    endfunction

    function automatic void shape_sample(input logic signed [tph_pkg::SAMPLE_W-1:0] smp,
                                         input bit lst);
        int unsigned   win;
        int unsigned   gp;
        int unsigned   cnt;
        longint        acc;
        longint        spread;
        pulse_result_t res;
        win = clip_window(reg_window);
        gp  = clip_gap(reg_gap);
        cnt = rec_count;
        if (cnt >= 2 * win + gp) begin
            if (!t_seen) begin
                t_hi = trap_acc;
                t_lo = trap_acc;
                t_seen = 1'b1;
            end else begin
                if (trap_acc > t_hi) t_hi = trap_acc;
                if (trap_acc < t_lo) t_lo = trap_acc;
            end
        end
        acc = longint'(trap_acc) + longint'(smp);
        if (cnt >= win) acc -= longint'(past_sample(win));
        if (cnt >= gp + win) acc -= longint'(past_sample(gp + win));
        if (cnt >= gp + 2 * win) acc += longint'(past_sample(gp + 2 * win));
        trap_acc = acc[tph_pkg::SUM_W-1:0];
        sample_hist[hist_wr] = smp;
        hist_wr = (hist_wr + 1) % LINE_DEPTH;
        if (rec_count < tph_pkg::MAX_RECORD) rec_count++;
        if (lst) begin
            if (t_seen) begin
                spread = longint'(t_hi) - longint'(t_lo);
                res.height_q8 = tph_pkg::HEIGHT_W'((spread <<< tph_pkg::FRAC_W) /
                                                   longint'(win));
                res.too_short = 1'b0;
            end else begin
                res.height_q8 = '0;
                res.too_short = 1'b1;
            end
            pending_heights.insert(pending_heights.size(), res);
            trap_acc = '0;
            rec_count = 0;
            t_hi = '0;
            t_lo = '0;
            t_seen = 1'b0;
        end
    endfunction

    task automatic send_sample(input logic signed [tph_pkg::SAMPLE_W-1:0] smp, input bit lst);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_last   <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shape_sample(smp, lst);
        samples_sent++;
    endtask

    // shape 0: full-range noise; otherwise baseline plus a step part way in
    task automatic send_pulse(input int unsigned len, input int unsigned shape, input bit close);
        int base;
        int amp;
        int val;
        base = int'($urandom_range(400)) - 200;
        amp  = int'($urandom_range(40000)) - 20000;
        for (int unsigned k = 0; k < len; k++) begin
            if (shape == 0) begin
                val = int'($urandom_range(65535)) - 32768;
            end else begin
                val = base + int'($urandom_range(30)) - 15;
                if (k >= len / 3) val += amp;
            end
            send_sample(tph_pkg::SAMPLE_W'(val), close && (k == len - 1));
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_heights.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input int unsigned win, input int unsigned gp);
        cfg_valid <= 1'b1;
        cfg_index <= tph_pkg::CFG_WINDOW;
        cfg_data  <= win[tph_pkg::CFG_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reg_window = win[tph_pkg::CFG_W-1:0];
        cfg_index <= tph_pkg::CFG_GAP;
        cfg_data  <= gp[tph_pkg::CFG_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reg_gap = gp[tph_pkg::CFG_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // reset values 500/100 need 1101 samples for a position, so a short record is too short
    task automatic test_reset_defaults();
        send_pulse(40, 1, 1'b1);
        wait_idle();
    endtask

    task automatic test_min_window();
        set_config(1, 0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd32767, 1'b1);
        wait_idle();
    endtask

    task automatic test_window_zero();
        set_config(0, 2);
        send_pulse(6, 0, 1'b1);
        send_pulse(4, 0, 1'b1);
        wait_idle();
    endtask

    task automatic test_config_mid_record();
        set_config(3, 2);
        send_pulse(5, 0, 1'b0);
        wait_idle();
        set_config(2, 4);
        send_pulse(12, 0, 1'b1);
        wait_idle();
    endtask

    // 2047/2047 saturate to 1024/1024; opposite full-scale steps at L = 1 give the top height
    task automatic test_full_scale();
        set_config(2047, 2047);
        send_pulse(24, 1, 1'b1);
        wait_idle();
        set_config(1, 0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        set_config(1, 0);
        hold_asked++;
        repeat (40) send_pulse(4, 1, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_records(input int unsigned n_items);
        int unsigned first;
        int unsigned span;
        int unsigned len;
        first = samples_sent;
        while (samples_sent - first < n_items) begin
            if ($urandom_range(3) == 0) begin
                wait_idle();
                set_config($urandom_range(12), $urandom_range(10));
            end
            span = 2 * clip_window(reg_window) + clip_gap(reg_gap);
            if ($urandom_range(99) < 15)
                len = $urandom_range(span, 1);
            else
                len = span + 1 + $urandom_range(12);
            send_pulse(len, $urandom_range(1), 1'b1);
        end
        wait_idle();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 17;
        rx_idle_pct = 52;
        test_reset_defaults();
        test_min_window();
        test_window_zero();
        test_config_mid_record();
        test_full_scale();
        test_random_records(160);

        tx_idle_pct = 52;
        rx_idle_pct = 17;
        test_random_records(160);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_output_backpressure();
        test_random_records(160);

        $display("Checked %0d pulse heights (%0d too short) from %0d samples in %0d cycles.",
                 heights_checked, short_seen, samples_sent, cycle_count);
        $display("Covered reset, extreme windows/gaps, mid-record changes, output stalls.");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", err_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
